>>> rtl/go_back_n_sender_window_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the go-back-n sender window core
// ---------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_WINDOW_CORE_MACROS_SVH
`define GO_BACK_N_SENDER_WINDOW_CORE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, disabled while in reset
`define GBNS_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled while in reset
`define GBNS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GBNS_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg)
`define GBNS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

>>> rtl/gbns_pkg.sv
// ---------------------------------------------------------------------------
// gbns_pkg
// Shared codes and controller/datapath interface types of the sender window.
// ---------------------------------------------------------------------------
`default_nettype none

package gbns_pkg;

    // fixed field widths
    localparam int CMD_W  = 2;
    localparam int KIND_W = 3;
    localparam int ACK_W  = 16;
    localparam int WIN_W  = 4;
    localparam int TOT_W  = 16;

    // item kinds on the input side
    localparam logic [CMD_W-1:0] CMD_DATA    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_SENT     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RESENT   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ACK_OK   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ACK_IGN  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REFUSED  = 3'd4;

    // configuration register indexes
    localparam logic CFG_WINDOW_SIZE  = 1'b0;
    localparam logic CFG_TOTAL_FRAMES = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic capture;      // latch the accepted input word
        logic exec_word;    // execute data/ack word and load the result
        logic tmo_init;     // start a resend walk at the window base
        logic resend_emit;  // load one resent frame, step the walk
    } ctrl_t;

    // datapath to controller status
    typedef struct packed {
        logic [CMD_W-1:0] cmd;            // kind of the latched word
        logic             none_outstanding;
        logic             resend_last;    // walk is at the newest frame
        logic             out_free;       // output register can be loaded
    } status_t;

endpackage

`default_nettype wire

>>> rtl/gbns_ctrl.sv
// ---------------------------------------------------------------------------
// gbns_ctrl
// Controller: accepts one word at a time and sequences its execution.
// ---------------------------------------------------------------------------
`default_nettype none

module gbns_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire gbns_pkg::status_t status,
    output gbns_pkg::ctrl_t        ctrl
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_RD   = 2'd2;
    localparam logic [1:0] ST_WR   = 2'd3;

    logic [1:0] state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb begin
        state_next       = state_reg;
        ctrl             = '0;
        ctrl.capture     = s_tvalid && (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (status.cmd)
                    gbns_pkg::CMD_DATA, gbns_pkg::CMD_ACK: begin
                        if (status.out_free) begin
                            ctrl.exec_word = 1'b1;
                            state_next     = ST_IDLE;
                        end
                    end
                    gbns_pkg::CMD_TIMEOUT: begin
                        if (status.none_outstanding) begin
                            state_next = ST_IDLE;
                        end else begin
                            ctrl.tmo_init = 1'b1;
                            state_next    = ST_RD;
                        end
                    end
                    default: begin
                        // unused code: no result
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_RD: begin
                // store read in flight
                state_next = ST_WR;
            end
            ST_WR: begin
                if (status.out_free) begin
                    ctrl.resend_emit = 1'b1;
                    state_next = status.resend_last ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/gbns_dpath.sv
// ---------------------------------------------------------------------------
// gbns_dpath
// Datapath: window pointers, frame store, config registers, result register.
// ---------------------------------------------------------------------------
`default_nettype none

module gbns_dpath #(
    parameter int MAX_WINDOW    = 8,
    parameter int SEQ_WIDTH     = 16,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration
    input  wire logic                           cfg_wr_en,
    input  wire logic                           cfg_addr,
    input  wire logic [gbns_pkg::TOT_W-1:0]     cfg_wdata,
    // input word fields
    input  wire logic [gbns_pkg::CMD_W-1:0]     in_cmd,
    input  wire logic [PAYLOAD_WIDTH-1:0]       in_payload,
    input  wire logic [gbns_pkg::ACK_W-1:0]     in_ack,
    // control
    input  wire gbns_pkg::ctrl_t                ctrl,
    output gbns_pkg::status_t                   status,
    // result register
    input  wire logic                           out_ready,
    output logic                                out_valid,
    output logic [gbns_pkg::KIND_W-1:0]         out_kind,
    output logic [SEQ_WIDTH-1:0]                out_seq,
    output logic [PAYLOAD_WIDTH-1:0]            out_payload,
    output logic [SEQ_WIDTH-1:0]                out_base,
    output logic                                out_done,
    output logic                                out_last
);

    localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int CW     = (SEQ_WIDTH > gbns_pkg::ACK_W) ? SEQ_WIDTH : gbns_pkg::ACK_W;
    localparam int WW     = (CNT_W > gbns_pkg::WIN_W) ? CNT_W : gbns_pkg::WIN_W;
    localparam int LW     = ((SEQ_WIDTH > CNT_W) ? SEQ_WIDTH : CNT_W) + 1;

    // advance a ring index by one, wrapping at the depth
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        idx_inc = (i == IDX_W'(MAX_WINDOW - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    // configuration registers
    logic [gbns_pkg::WIN_W-1:0] win_reg;
    logic [gbns_pkg::TOT_W-1:0] total_reg;

    // captured input word
    logic [gbns_pkg::CMD_W-1:0] cmd_reg;
    logic [PAYLOAD_WIDTH-1:0]   pay_reg;
    logic [gbns_pkg::ACK_W-1:0] ack_reg;

    // window pointers and resend walk
    logic [SEQ_WIDTH-1:0] base_reg, next_reg, ptr_seq_reg;
    logic [IDX_W-1:0]     base_idx_reg, next_idx_reg, ptr_idx_reg;

    // frame store
    logic [PAYLOAD_WIDTH-1:0] store_mem [MAX_WINDOW];
    logic [PAYLOAD_WIDTH-1:0] rd_data_reg;

    // result register
    logic                        out_valid_reg;
    logic [gbns_pkg::KIND_W-1:0] out_kind_reg;
    logic [SEQ_WIDTH-1:0]        out_seq_reg, out_base_reg;
    logic [PAYLOAD_WIDTH-1:0]    out_pay_reg;
    logic                        out_done_reg, out_last_reg;

    // decision logic
    logic [WW-1:0]        win_ext, eff_w_full;
    logic [CNT_W-1:0]     eff_w;
    logic [CW-1:0]        seq_max, tot_ext, eff_total, ack_ext;
    logic [LW-1:0]        limit;
    logic                 data_ok, ack_ok, done_now, done_ack;
    logic [SEQ_WIDTH-1:0] ack_seq, new_base;
    logic [CNT_W-1:0]     adv;
    logic [CNT_W:0]       idx_sum;
    logic [IDX_W-1:0]     new_base_idx;
    logic                 store_wr;

    // effective window and frame total
    always_comb begin
        win_ext    = WW'(win_reg);
        if (win_ext == '0) begin
            eff_w_full = WW'(1);
        end else if (win_ext > WW'(MAX_WINDOW)) begin
            eff_w_full = WW'(MAX_WINDOW);
        end else begin
            eff_w_full = win_ext;
        end
        eff_w     = CNT_W'(eff_w_full);
        seq_max   = CW'({SEQ_WIDTH{1'b1}});
        tot_ext   = CW'(total_reg);
        eff_total = (tot_ext > seq_max) ? seq_max : tot_ext;
    end

    // data and acknowledgement checks
    always_comb begin
        limit    = LW'(base_reg) + LW'(eff_w);
        data_ok  = (LW'(next_reg) < limit) && (CW'(next_reg) < eff_total);
        ack_ext  = CW'(ack_reg);
        ack_ok   = (ack_ext >= CW'(base_reg)) && (ack_ext < CW'(next_reg));
        ack_seq  = SEQ_WIDTH'(ack_reg);
        new_base = SEQ_WIDTH'(ack_ext + CW'(1));
        adv      = CNT_W'(new_base - base_reg);
        idx_sum  = (CNT_W + 1)'(base_idx_reg) + (CNT_W + 1)'(adv);
        if (idx_sum >= (CNT_W + 1)'(MAX_WINDOW)) begin
            new_base_idx = IDX_W'(idx_sum - (CNT_W + 1)'(MAX_WINDOW));
        end else begin
            new_base_idx = IDX_W'(idx_sum);
        end
        done_now = (CW'(base_reg) >= eff_total);
        done_ack = (CW'(new_base) >= eff_total);
        store_wr = ctrl.exec_word && (cmd_reg == gbns_pkg::CMD_DATA) && data_ok;
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg   <= gbns_pkg::WIN_W'(4);
            total_reg <= gbns_pkg::TOT_W'(10);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                gbns_pkg::CFG_WINDOW_SIZE:  win_reg   <= cfg_wdata[gbns_pkg::WIN_W-1:0];
                gbns_pkg::CFG_TOTAL_FRAMES: total_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input capture
    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            cmd_reg <= in_cmd;
            pay_reg <= in_payload;
            ack_reg <= in_ack;
        end
    end

    // window pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg     <= '0;
            next_reg     <= '0;
            base_idx_reg <= '0;
            next_idx_reg <= '0;
        end else if (ctrl.exec_word) begin
            if (store_wr) begin
                next_reg     <= next_reg + SEQ_WIDTH'(1);
                next_idx_reg <= idx_inc(next_idx_reg);
            end
            if ((cmd_reg == gbns_pkg::CMD_ACK) && ack_ok) begin
                base_reg     <= new_base;
                base_idx_reg <= new_base_idx;
            end
        end
    end

    // resend walk pointer
    always_ff @(posedge aclk) begin
        if (ctrl.tmo_init) begin
            ptr_seq_reg <= base_reg;
            ptr_idx_reg <= base_idx_reg;
        end else if (ctrl.resend_emit) begin
            ptr_seq_reg <= ptr_seq_reg + SEQ_WIDTH'(1);
            ptr_idx_reg <= idx_inc(ptr_idx_reg);
        end
    end

    // frame store, registered read at the walk pointer
    always_ff @(posedge aclk) begin
        if (store_wr) begin
            store_mem[next_idx_reg] <= pay_reg;
        end
        rd_data_reg <= store_mem[ptr_idx_reg];
    end

    // result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.exec_word || ctrl.resend_emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (ctrl.resend_emit) begin
            out_kind_reg <= gbns_pkg::KIND_RESENT;
            out_seq_reg  <= ptr_seq_reg;
            out_pay_reg  <= rd_data_reg;
            out_base_reg <= base_reg;
            out_done_reg <= done_now;
            out_last_reg <= status.resend_last;
        end else if (ctrl.exec_word) begin
            out_last_reg <= 1'b1;
            if (cmd_reg == gbns_pkg::CMD_DATA) begin
                out_kind_reg <= data_ok ? gbns_pkg::KIND_SENT : gbns_pkg::KIND_REFUSED;
                out_seq_reg  <= next_reg;
                out_pay_reg  <= data_ok ? pay_reg : '0;
                out_base_reg <= base_reg;
                out_done_reg <= done_now;
            end else begin
                out_kind_reg <= ack_ok ? gbns_pkg::KIND_ACK_OK : gbns_pkg::KIND_ACK_IGN;
                out_seq_reg  <= ack_seq;
                out_pay_reg  <= '0;
                out_base_reg <= ack_ok ? new_base : base_reg;
                out_done_reg <= ack_ok ? done_ack : done_now;
            end
        end
    end

    // status to the controller
    always_comb begin
        status.cmd              = cmd_reg;
        status.none_outstanding = (base_reg == next_reg);
        status.resend_last      = ((ptr_seq_reg + SEQ_WIDTH'(1)) == next_reg);
        status.out_free         = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign out_kind    = out_kind_reg;
    assign out_seq     = out_seq_reg;
    assign out_payload = out_pay_reg;
    assign out_base    = out_base_reg;
    assign out_done    = out_done_reg;
    assign out_last    = out_last_reg;

endmodule

`default_nettype wire

>>> rtl/go_back_n_sender_window_core.sv
// Sequence: a word is accepted while idle; a data or ack result is loaded into the output register
// in the execute state once that register is free, the first resent frame in the write state.
// Data and ack words are accepted, then executed.
// A timeout is accepted and executed, then each resent frame takes a registered store read and a write.
// Reset (aresetn low, synchronous) clears the window to empty, restores window size 4 and
// frame total 10; the frame store is not cleared.
// ---------------------------------------------------------------------------
// go_back_n_sender_window_core
// Go-back-N sender window: numbers, stores, acknowledges and resends frames.
// ---------------------------------------------------------------------------
`default_nettype none

`include "go_back_n_sender_window_core_macros.svh"

module go_back_n_sender_window_core #(
    parameter int MAX_WINDOW    = 8,
    parameter int SEQ_WIDTH     = 16,
    parameter int PAYLOAD_WIDTH = 32,
    localparam int S_TDATA_W = ((PAYLOAD_WIDTH + gbns_pkg::ACK_W + 7) / 8) * 8,
    localparam int M_TDATA_W = ((2 * SEQ_WIDTH + PAYLOAD_WIDTH + 7) / 8) * 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_addr,
    input  wire logic [gbns_pkg::TOT_W-1:0]    cfg_wdata,
    // input words
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [S_TDATA_W-1:0]          s_tdata,   // frame_payload, ack_seq
    input  wire logic [gbns_pkg::CMD_W-1:0]    s_tuser,   // cmd
    // result words
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [M_TDATA_W-1:0]               m_tdata,   // seq_no, payload_out, window_base
    output logic [gbns_pkg::KIND_W:0]          m_tuser,   // kind, all_done
    output logic                               m_tlast
);

    gbns_pkg::ctrl_t   ctrl;
    gbns_pkg::status_t status;

    logic [gbns_pkg::KIND_W-1:0] out_kind;
    logic [SEQ_WIDTH-1:0]        out_seq, out_base;
    logic [PAYLOAD_WIDTH-1:0]    out_payload;
    logic                        out_done;

    gbns_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .ctrl     (ctrl)
    );

    gbns_dpath #(
        .MAX_WINDOW    (MAX_WINDOW),
        .SEQ_WIDTH     (SEQ_WIDTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_cmd      (s_tuser),
        .in_payload  (s_tdata[PAYLOAD_WIDTH-1:0]),
        .in_ack      (s_tdata[PAYLOAD_WIDTH +: gbns_pkg::ACK_W]),
        .ctrl        (ctrl),
        .status      (status),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_kind    (out_kind),
        .out_seq     (out_seq),
        .out_payload (out_payload),
        .out_base    (out_base),
        .out_done    (out_done),
        .out_last    (m_tlast)
    );

    // pack the result word
    assign m_tdata = M_TDATA_W'({out_base, out_payload, out_seq});
    assign m_tuser = {out_done, out_kind};

    // one word in flight: no accept in the cycle after an accept
    `GBNS_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready,
        "input accepted while a word is in flight")
    // a resent frame never lies below the window base
    `GBNS_ASSERT_IMPLIES(a_resend_in_window, aclk, aresetn,
        m_tvalid && (out_kind == gbns_pkg::KIND_RESENT), out_seq >= out_base,
        "resent frame below window base")
    // single-result kinds always close their word
    `GBNS_ASSERT_IMPLIES(a_single_last, aclk, aresetn,
        m_tvalid && (out_kind != gbns_pkg::KIND_RESENT), m_tlast,
        "single result without last")

endmodule

`default_nettype wire

>>> bench/go_back_n_sender_window_checker.sv
// ----------------------------------------------------------------------------
// Go-back-N sender window checker
// Watches the configuration port and both word channels of the sender window,
// keeps its own copy of the window state, works out the result words every
// accepted input word should cause and compares them in order with the words
// the core emits. Hands its failure count and window position to the bench.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_checker
    import gbns_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_addr,
    input  wire logic [TOT_W-1:0]   cfg_wdata,
    input  wire logic               s_tvalid,
    input  wire logic               s_tready,
    input  wire logic [47:0]        s_tdata,   // frame_payload, ack_seq
    input  wire logic [CMD_W-1:0]   s_tuser,   // cmd
    input  wire logic               m_tvalid,
    input  wire logic               m_tready,
    input  wire logic [63:0]        m_tdata,   // seq_no, payload_out, window_base
    input  wire logic [KIND_W:0]    m_tuser,   // kind, all_done
    input  wire logic               m_tlast,
    output int                      fails,
    output int                      pending,
    output logic [15:0]             base_now,
    output logic [15:0]             next_now
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_OUTSTANDING = 8;
    localparam int RING_W          = $clog2(MAX_OUTSTANDING);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [15:0]       seq_no;
        logic [31:0]       payload;
        logic [15:0]       base;
        logic              done;
        logic              last;
    } window_report_t;

    // result words still to come, oldest first
    window_report_t   due_reports[$];
    window_report_t   head;
    int               fail_count = 0;
    int               waiting = 0;

    // shadow of the sender window
    logic [WIN_W-1:0] win_reg;
    logic [TOT_W-1:0] total_reg;
    logic [15:0]      base_q;
    logic [15:0]      next_q;
    logic [31:0]      ring [MAX_OUTSTANDING];

    assign fails    = fail_count;
    assign pending  = waiting;
    assign base_now = base_q;
    assign next_now = next_q;

    // queue one result word, stamped with the window base after this word
    task automatic note_report(input logic [KIND_W-1:0] kind, input logic [15:0] seq,
                               input logic [31:0] pay, input logic last);
        window_report_t r;
        r.kind    = kind;
        r.seq_no  = seq;
        r.payload = pay;
        r.base    = base_q;
        r.done    = (base_q >= total_reg);
        r.last    = last;
        due_reports.push_back(r);
    endtask

    // advance the window for one accepted input word
    task automatic advance_window(input logic [CMD_W-1:0] cmd, input logic [31:0] pay,
                                  input logic [15:0] ack);
        int unsigned w;
        int unsigned s;
        int unsigned n;
        // 0 behaves as 1, anything past the ring as the full ring
        w = 32'(win_reg);
        if (w < 1) w = 1;
        if (w > MAX_OUTSTANDING) w = MAX_OUTSTANDING;
        case (cmd)
            CMD_DATA: begin
                if (next_q < base_q + w && next_q < total_reg) begin
                    ring[next_q[RING_W-1:0]] = pay;
                    note_report(KIND_SENT, next_q, pay, 1'b1);
                    next_q = next_q + 16'd1;
                end else begin
                    note_report(KIND_REFUSED, next_q, '0, 1'b1);
                end
            end
            CMD_ACK: begin
                // cumulative ack, only for frames actually outstanding
                if (ack >= base_q && ack < next_q) begin
                    base_q = ack + 16'd1;
                    note_report(KIND_ACK_OK, ack, '0, 1'b1);
                end else begin
                    note_report(KIND_ACK_IGN, ack, '0, 1'b1);
                end
            end
            CMD_TIMEOUT: begin
                // go back to the base and replay everything outstanding
                s = 32'(base_q);
                n = 0;
                while (s < next_q && n < MAX_OUTSTANDING) begin
                    note_report(KIND_RESENT, s[15:0], ring[s[RING_W-1:0]],
                                (s + 1 == next_q) || (n == MAX_OUTSTANDING - 1));
                    s++;
                    n++;
                end
            end
            default: ;  // unused code, no result
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            win_reg   = 4'd4;
            total_reg = 16'd10;
            base_q    = '0;
            next_q    = '0;
            due_reports.delete();
        end else begin
            // result side first: a word leaving now belongs to earlier input
            if (m_tvalid && m_tready) begin
                if (due_reports.size() == 0) begin
                    $error("unexpected result word: kind %0d seq_no %0d",
                           m_tuser[KIND_W-1:0], m_tdata[15:0]);
                    fail_count++;
                end else begin
                    head = due_reports.pop_front();
                    check_field("kind", 32'(head.kind), 32'(m_tuser[KIND_W-1:0]));
                    check_field("seq_no", 32'(head.seq_no), 32'(m_tdata[15:0]));
                    check_field("payload_out", head.payload, m_tdata[47:16]);
                    check_field("window_base", 32'(head.base), 32'(m_tdata[63:48]));
                    check_field("all_done", 32'(head.done), 32'(m_tuser[KIND_W]));
                    check_field("last", 32'(head.last), 32'(m_tlast));
                end
            end
            if (cfg_wr_en) begin
                if (cfg_addr == CFG_WINDOW_SIZE)
                    win_reg = cfg_wdata[WIN_W-1:0];
                else
                    total_reg = cfg_wdata;
            end
            if (s_tvalid && s_tready)
                advance_window(s_tuser, s_tdata[31:0], s_tdata[47:32]);
        end
        waiting = due_reports.size();
    end

endmodule

>>> bench/go_back_n_sender_window_core_test.sv
// ----------------------------------------------------------------------------
// Go-back-N sender window core bench
// Drives data, acknowledgement and timeout words into the core under random
// back-pressure on both channels, rewrites the window size and frame total
// between phases, and leaves all checking to the window checker.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gbns_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 24;
    localparam int PHASES       = 9;
    localparam int PHASE_WORDS  = 32;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic               cfg_addr = 1'b0;
    logic [TOT_W-1:0]   cfg_wdata = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [47:0]        s_tdata = '0;    // frame_payload, ack_seq
    logic [CMD_W-1:0]   s_tuser = '0;    // cmd
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [63:0]        m_tdata;         // seq_no, payload_out, window_base
    logic [KIND_W:0]    m_tuser;         // kind, all_done
    logic               m_tlast;

    int                 fails;
    int                 pending;
    logic [15:0]        base_now;
    logic [15:0]        next_now;
    bit                 steady = 1'b0;   // no idling on either side
    int                 cycles = 0;

    go_back_n_sender_window_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    go_back_n_sender_window_checker window_chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .fails     (fails),
        .pending   (pending),
        .base_now  (base_now),
        .next_now  (next_now)
    );

    always #5 aclk = ~aclk;

    // receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 9);
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // offer one input word, holding it until the core takes it
    task automatic offer(input logic [CMD_W-1:0] cmd, input logic [31:0] pay,
                         input logic [15:0] ack);
        @(negedge aclk);
        while (!steady && $urandom_range(0, 99) < 9) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {ack, pay};
        do @(posedge aclk); while (!s_tready);
    endtask

    // drop valid, drain every result, then give no-result words time to finish
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_TICKS) @(negedge aclk);
    endtask

    // both registers back to back, write enable held across the pair
    task automatic write_regs(input logic [TOT_W-1:0] win_word,
                              input logic [TOT_W-1:0] total);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_WINDOW_SIZE;
        cfg_wdata <= win_word;
        @(negedge aclk);
        cfg_addr  <= CFG_TOTAL_FRAMES;
        cfg_wdata <= total;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // one random word, mostly data and acks, the acks mostly inside the window
    task automatic random_word();
        int unsigned pick;
        logic [31:0] pay;
        logic [31:0] junk;
        logic [15:0] ack;
        pick = $urandom_range(0, 99);
        pay  = $urandom;
        junk = $urandom;
        if (pick < 45) begin
            offer(CMD_DATA, pay, junk[15:0]);
        end else if (pick < 80) begin
            if (next_now != base_now && $urandom_range(0, 3) != 0) begin
                ack = 16'($urandom_range(32'(base_now), 32'(next_now) - 1));
            end else begin
                case ($urandom_range(0, 2))
                    0:       ack = base_now - 16'd1;
                    1:       ack = next_now;
                    default: ack = junk[31:16];
                endcase
            end
            offer(CMD_ACK, pay, ack);
        end else if (pick < 94) begin
            offer(CMD_TIMEOUT, pay, junk[15:0]);
        end else begin
            offer(CMD_UNUSED, pay, junk[15:0]);
        end
    endtask

    initial begin
        logic [3:0]        win;
        logic [TOT_W-1:0]  total;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // defaults: window 4, ten frames
        offer(CMD_TIMEOUT, $urandom, 16'($urandom));     // nothing outstanding
        offer(CMD_UNUSED, $urandom, 16'($urandom));
        offer(CMD_ACK, 32'hFFFF_FFFF, 16'd0);            // nothing to ack yet
        offer(CMD_DATA, 32'h0000_0000, 16'hFFFF);
        offer(CMD_DATA, 32'hFFFF_FFFF, 16'h0000);
        offer(CMD_DATA, 32'hA5A5_5A5A, 16'($urandom));
        offer(CMD_DATA, 32'h5A5A_A5A5, 16'($urandom));
        offer(CMD_DATA, $urandom, 16'($urandom));        // window full
        offer(CMD_TIMEOUT, $urandom, 16'($urandom));     // replays 0..3
        offer(CMD_ACK, $urandom, 16'd1);
        offer(CMD_ACK, $urandom, 16'd0);                 // below the base
        offer(CMD_ACK, $urandom, 16'hFFFF);              // far above
        offer(CMD_ACK, $urandom, 16'd4);                 // equal to next, not sent
        offer(CMD_DATA, $urandom, 16'($urandom));
        offer(CMD_TIMEOUT, $urandom, 16'($urandom));
        offer(CMD_ACK, $urandom, 16'd4);
        settle();

        // window above the ring size behaves as the full ring
        write_regs(16'd15, 16'd10);
        repeat (6) offer(CMD_DATA, $urandom, 16'($urandom));  // last one past the total
        offer(CMD_TIMEOUT, $urandom, 16'($urandom));
        offer(CMD_ACK, $urandom, 16'd9);                 // transfer complete
        offer(CMD_ACK, $urandom, 16'd9);
        settle();

        // random phases, each under its own window and frame total
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       win = 4'd0;
                1:       win = 4'd8;
                2:       win = 4'd1;
                3:       win = 4'd15;
                6:       win = 4'd12;
                default: win = 4'($urandom_range(1, 8));
            endcase
            case (p)
                2:       total = 16'd1;
                5:       total = 16'hFFFF;
                7:       total = 16'd0;
                default: total = 16'(32'(next_now) + $urandom_range(6, 40));
            endcase
            steady = (p == 4 || p == 5);
            write_regs({12'($urandom), win}, total);
            repeat (PHASE_WORDS) random_word();
            settle();
        end
        steady = 1'b0;

        if (fails == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
